// ===== rtl/mcas_pkg.sv =====
// Shared widths, cell command codes and cell interface structs of the assignment solver.
package mcas_pkg;

    localparam int MAX_ROWS = 32;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = 5;
    localparam int COL_W    = 6;
    localparam int OWNER_W  = 6;
    localparam int LINK_W   = 7;
    localparam int POT_W    = 48;
    localparam int COST_W   = 32;
    localparam int EDGE_W   = 16;
    localparam int EPOCH_W  = 8;
    localparam int NCELL    = MAX_COLS + 1;
    localparam int CELLS    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int WORD_W   = EPOCH_W + COST_W + EDGE_W;

    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_SOLVE_INIT = 3'd1;
    localparam logic [2:0] CMD_PHASE_INIT = 3'd2;
    localparam logic [2:0] CMD_VISIT      = 3'd3;
    localparam logic [2:0] CMD_UPDATE     = 3'd4;
    localparam logic [2:0] CMD_MOVE       = 3'd5;

    typedef struct packed {
        logic [2:0]                cmd;
        logic [LINK_W-1:0]         sel;
        logic [OWNER_W-1:0]        owner;
        logic signed [POT_W-1:0]   value;
    } cell_cmd_t;

    typedef struct packed {
        logic                      hit;
        logic [LINK_W-1:0]         col;
        logic [LINK_W-1:0]         from;
        logic signed [POT_W-1:0]   costu;
    } scan_bus_t;

    typedef struct packed {
        logic                      have;
        logic signed [POT_W-1:0]   delta;
        logic [LINK_W-1:0]         best;
    } token_t;

    typedef struct packed {
        logic [OWNER_W-1:0]        owner;
        logic signed [POT_W-1:0]   u;
        logic [LINK_W-1:0]         link;
    } cell_stat_t;

endpackage

// ===== rtl/min_cost_assignment_solver_core.sv =====
// Top level of the assignment solver: entry store, solve sequencer and column cell chain.
//
//   channel   handshake            payload
//   entry     start / busy         row_index col_index entry_cost edge_id last_entry
//   result    valid (strobe)       out_row out_col out_edge cost_sum status last_result
//   config    wr_en                wr_index wr_data
//
// An entry is read from the cell store, then compared and written back. The length of a
// search step is set by the column scan through the cost memory port and the minimum wave
// down the cell chain; a row needs up to its index of such steps plus its augmenting hops.
// Results come out one per owned column, or as a single error result, then busy drops.
// After reset, and after every 255 solves, a clearing pass sweeps all 2048 words of the cell
// store while busy is high. The receiver cannot stall: each result is valid for one cycle.
module min_cost_assignment_solver_core
    import mcas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ROW_W-1:0]         row_index,
    input  logic [COL_W-1:0]         col_index,
    input  logic signed [COST_W-1:0] entry_cost,
    input  logic [EDGE_W-1:0]        edge_id,
    input  logic                     last_entry,
    input  logic                     wr_en,
    input  logic                     wr_index,
    input  logic [6:0]               wr_data,
    output logic                     valid,
    output logic [ROW_W-1:0]         out_row,
    output logic [COL_W-1:0]         out_col,
    output logic [EDGE_W-1:0]        out_edge,
    output logic signed [39:0]       cost_sum,
    output logic                     status,
    output logic                     last_result
);

    localparam int TOTAL_W = 40;
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic [LINK_W-1:0] SCAN_LAST = LINK_W'(MAX_COLS + 2);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LOAD     = 4'd2;
    localparam logic [3:0] S_SOLVE    = 4'd3;
    localparam logic [3:0] S_PHASE    = 4'd4;
    localparam logic [3:0] S_VISIT    = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_PICK     = 4'd7;
    localparam logic [3:0] S_UPDATE   = 4'd8;
    localparam logic [3:0] S_CHECK    = 4'd9;
    localparam logic [3:0] S_AUG_LINK = 4'd10;
    localparam logic [3:0] S_AUG_MOVE = 4'd11;
    localparam logic [3:0] S_OUT      = 4'd12;
    localparam logic [3:0] S_DRAIN    = 4'd13;
    localparam logic [3:0] S_ERR      = 4'd14;
    localparam logic [3:0] S_FINISH   = 4'd15;

    logic [3:0]               state_reg, state_next;
    logic [5:0]               n_reg, n_next;
    logic [6:0]               m_reg, m_next;
    logic [EPOCH_W-1:0]       epoch_reg, epoch_next;
    logic [ADDR_W-1:0]        clr_reg, clr_next;
    logic [ROW_W-1:0]         ent_row_reg, ent_row_next;
    logic [COL_W-1:0]         ent_col_reg, ent_col_next;
    logic signed [COST_W-1:0] ent_cost_reg, ent_cost_next;
    logic [EDGE_W-1:0]        ent_edge_reg, ent_edge_next;
    logic                     ent_last_reg, ent_last_next;
    logic [OWNER_W-1:0]       row_i_reg, row_i_next;
    logic [LINK_W-1:0]        cur_reg, cur_next;
    logic [OWNER_W-1:0]       r0_reg, r0_next;
    logic signed [POT_W-1:0]  ur0_reg, ur0_next;
    logic [LINK_W-1:0]        cnt_reg, cnt_next;
    logic signed [POT_W-1:0]  delta_reg, delta_next;
    logic [LINK_W-1:0]        best_reg, best_next;
    logic [LINK_W-1:0]        prev_reg, prev_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic [LINK_W-1:0]        rd_col_reg, rd_col_next;
    scan_bus_t                bus_reg, bus_next;
    logic                     out_pend_reg, out_pend_next;
    logic [ROW_W-1:0]         out_prow_reg, out_prow_next;
    logic [COL_W-1:0]         out_pcol_reg, out_pcol_next;
    logic [OWNER_W-1:0]       out_cnt_reg, out_cnt_next;
    logic                     valid_reg, valid_next;
    logic [ROW_W-1:0]         out_row_reg, out_row_next;
    logic [COL_W-1:0]         out_col_reg, out_col_next;
    logic [EDGE_W-1:0]        out_edge_reg, out_edge_next;
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic                     status_reg, status_next;
    logic                     last_reg, last_next;

    logic [5:0]               n_eff;
    logic [6:0]               m_eff;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
    logic [WORD_W-1:0]        ram_wdata, ram_rdata;
    logic [EPOCH_W-1:0]       q_epoch;
    logic signed [COST_W-1:0] q_cost;
    logic [EDGE_W-1:0]        q_edge;
    logic [OWNER_W-1:0]       r0_m1;
    logic [LINK_W-1:0]        out_j;
    logic [OWNER_W-1:0]       out_owner;
    logic [OWNER_W-1:0]       out_owner_m1;
    cell_cmd_t                cmd_bus;
    token_t                   tok [NCELL+1];
    cell_stat_t               stat [NCELL];

    assign q_epoch = ram_rdata[WORD_W-1 -: EPOCH_W];
    assign q_cost  = ram_rdata[EDGE_W +: COST_W];
    assign q_edge  = ram_rdata[EDGE_W-1:0];

    assign n_eff = (n_reg == '0) ? 6'd1 : ((n_reg > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : n_reg);
    assign m_eff = (m_reg == '0) ? 7'd1 : ((m_reg > 7'(MAX_COLS)) ? 7'(MAX_COLS) : m_reg);

    assign r0_m1        = r0_reg - OWNER_W'(1);
    assign out_j        = cnt_reg + LINK_W'(1);
    assign out_owner    = stat[out_j].owner;
    assign out_owner_m1 = out_owner - OWNER_W'(1);

    mcas_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_cell_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tok[0] = '0;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        mcas_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (LINK_W'(k)),
            .cmd       (cmd_bus),
            .scan      (bus_reg),
            .token_in  (tok[k]),
            .token_out (tok[k+1]),
            .stat      (stat[k])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        epoch_next    = epoch_reg;
        clr_next      = clr_reg;
        ent_row_next  = ent_row_reg;
        ent_col_next  = ent_col_reg;
        ent_cost_next = ent_cost_reg;
        ent_edge_next = ent_edge_reg;
        ent_last_next = ent_last_reg;
        row_i_next    = row_i_reg;
        cur_next      = cur_reg;
        r0_next       = r0_reg;
        ur0_next      = ur0_reg;
        cnt_next      = cnt_reg;
        delta_next    = delta_reg;
        best_next     = best_reg;
        prev_next     = prev_reg;
        rd_pend_next  = 1'b0;
        rd_col_next   = rd_col_reg;
        out_pend_next = 1'b0;
        out_prow_next = out_prow_reg;
        out_pcol_next = out_pcol_reg;
        out_cnt_next  = out_cnt_reg;
        valid_next    = 1'b0;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_edge_next = out_edge_reg;
        total_next    = total_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = {ent_row_reg, ent_col_reg};
        ram_wdata     = {epoch_reg, ent_cost_reg, ent_edge_reg};
        ram_raddr     = {row_index, col_index};
        cmd_bus       = '0;

        if (wr_en)
        begin
            if (wr_index == REG_NUM_ROWS)
            begin
                n_next = wr_data[5:0];
            end
            else
            begin
                m_next = wr_data;
            end
        end

        // scan pipeline: cost word back from memory, reduce by the row potential
        bus_next.hit   = rd_pend_reg && (q_epoch == epoch_reg);
        bus_next.col   = rd_col_reg;
        bus_next.from  = cur_reg;
        bus_next.costu = {{(POT_W-COST_W){q_cost[COST_W-1]}}, q_cost} - ur0_reg;

        // result pipeline: emit the owned cell read in the previous cycle
        if (out_pend_reg)
        begin
            valid_next    = 1'b1;
            out_row_next  = out_prow_reg;
            out_col_next  = out_pcol_reg;
            out_edge_next = q_edge;
            total_next    = total_reg + {{(TOTAL_W-COST_W){q_cost[COST_W-1]}}, q_cost};
            status_next   = 1'b0;
            last_next     = (OWNER_W'(out_cnt_reg + OWNER_W'(1)) == n_eff);
            out_cnt_next  = out_cnt_reg + OWNER_W'(1);
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    epoch_next = EPOCH_W'(1);
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ent_row_next  = row_index;
                    ent_col_next  = col_index;
                    ent_cost_next = entry_cost;
                    ent_edge_next = edge_id;
                    ent_last_next = last_entry;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                // keep the cheapest entry; on a tie the earlier one stays
                if (q_epoch != epoch_reg || ent_cost_reg < q_cost)
                begin
                    ram_we = 1'b1;
                end
                state_next = ent_last_reg ? S_SOLVE : S_IDLE;
            end
            S_SOLVE:
            begin
                if ({1'b0, n_eff} > m_eff)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    cmd_bus.cmd = CMD_SOLVE_INIT;
                    row_i_next  = OWNER_W'(1);
                    state_next  = S_PHASE;
                end
            end
            S_PHASE:
            begin
                cmd_bus.cmd   = CMD_PHASE_INIT;
                cmd_bus.owner = row_i_reg;
                cur_next      = '0;
                state_next    = S_VISIT;
            end
            S_VISIT:
            begin
                cmd_bus.cmd = CMD_VISIT;
                cmd_bus.sel = cur_reg;
                r0_next     = stat[cur_reg].owner;
                ur0_next    = stat[cur_reg].u;
                cnt_next    = '0;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                ram_raddr    = {r0_m1[ROW_W-1:0], cnt_reg[COL_W-1:0]};
                rd_pend_next = (cnt_reg < m_eff);
                rd_col_next  = cnt_reg + LINK_W'(1);
                cnt_next     = cnt_reg + LINK_W'(1);
                // hold until the minimum wave leaves the last cell
                if (cnt_reg == SCAN_LAST)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (!tok[NCELL].have)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    delta_next = tok[NCELL].delta;
                    best_next  = tok[NCELL].best;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd_bus.cmd   = CMD_UPDATE;
                cmd_bus.value = delta_reg;
                cur_next      = best_reg;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (stat[cur_reg].owner != '0) ? S_VISIT : S_AUG_LINK;
            end
            S_AUG_LINK:
            begin
                prev_next  = stat[cur_reg].link;
                state_next = S_AUG_MOVE;
            end
            S_AUG_MOVE:
            begin
                // shift the row, with its potential, one hop along the path
                cmd_bus.cmd   = CMD_MOVE;
                cmd_bus.sel   = cur_reg;
                cmd_bus.owner = stat[prev_reg].owner;
                cmd_bus.value = stat[prev_reg].u;
                cur_next      = prev_reg;
                if (prev_reg == '0)
                begin
                    if (row_i_reg == n_eff)
                    begin
                        cnt_next     = '0;
                        out_cnt_next = '0;
                        total_next   = '0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        row_i_next = row_i_reg + OWNER_W'(1);
                        state_next = S_PHASE;
                    end
                end
                else
                begin
                    state_next = S_AUG_LINK;
                end
            end
            S_OUT:
            begin
                ram_raddr     = {out_owner_m1[ROW_W-1:0], cnt_reg[COL_W-1:0]};
                out_pend_next = (out_owner != '0);
                out_prow_next = out_owner_m1[ROW_W-1:0];
                out_pcol_next = cnt_reg[COL_W-1:0];
                cnt_next      = cnt_reg + LINK_W'(1);
                if (cnt_reg == m_eff - 7'd1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_ERR:
            begin
                valid_next    = 1'b1;
                out_row_next  = '0;
                out_col_next  = '0;
                out_edge_next = '0;
                total_next    = '0;
                status_next   = 1'b1;
                last_next     = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // advance the epoch: every stored cell turns stale at once
                epoch_next = epoch_reg + EPOCH_W'(1);
                if (epoch_reg == '1)
                begin
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            n_reg        <= 6'd1;
            m_reg        <= 7'd1;
            epoch_reg    <= EPOCH_W'(1);
            clr_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            bus_reg      <= '0;
            out_pend_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            m_reg        <= m_next;
            epoch_reg    <= epoch_next;
            clr_reg      <= clr_next;
            rd_pend_reg  <= rd_pend_next;
            bus_reg      <= bus_next;
            out_pend_reg <= out_pend_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_row_reg   <= ent_row_next;
        ent_col_reg   <= ent_col_next;
        ent_cost_reg  <= ent_cost_next;
        ent_edge_reg  <= ent_edge_next;
        ent_last_reg  <= ent_last_next;
        row_i_reg     <= row_i_next;
        cur_reg       <= cur_next;
        r0_reg        <= r0_next;
        ur0_reg       <= ur0_next;
        cnt_reg       <= cnt_next;
        delta_reg     <= delta_next;
        best_reg      <= best_next;
        prev_reg      <= prev_next;
        rd_col_reg    <= rd_col_next;
        out_prow_reg  <= out_prow_next;
        out_pcol_reg  <= out_pcol_next;
        out_cnt_reg   <= out_cnt_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_edge_reg  <= out_edge_next;
        total_reg     <= total_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign valid       = valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign out_edge    = out_edge_reg;
    assign cost_sum    = total_reg;
    assign status      = status_reg;
    assign last_result = last_reg;

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy)
        else $error("result strobe outside a solve");

    a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status |-> last_result)
        else $error("error result not marked final");

    a_one_final: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last_result |=> !valid)
        else $error("result after the final transaction of a solve");

endmodule

// ===== rtl/mcas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mcas_cell.sv =====
// One column cell: potentials, slack, owner, back link, and one stage of the minimum chain.
module mcas_cell
    import mcas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LINK_W-1:0] cell_idx,
    input  cell_cmd_t         cmd,
    input  scan_bus_t         scan,
    input  token_t            token_in,
    output token_t            token_out,
    output cell_stat_t        stat
);

    logic signed [POT_W-1:0] v_reg, v_next;
    logic signed [POT_W-1:0] u_reg, u_next;
    logic signed [POT_W-1:0] slack_reg, slack_next;
    logic                    finite_reg, finite_next;
    logic                    visited_reg, visited_next;
    logic [OWNER_W-1:0]      owner_reg, owner_next;
    logic [LINK_W-1:0]       link_reg, link_next;
    token_t                  token_reg, token_next;
    logic signed [POT_W-1:0] cand;

    always_comb
    begin
        v_next       = v_reg;
        u_next       = u_reg;
        slack_next   = slack_reg;
        finite_next  = finite_reg;
        visited_next = visited_reg;
        owner_next   = owner_reg;
        link_next    = link_reg;
        cand         = scan.costu - v_reg;

        // relax this column when its cost word comes by
        if (scan.hit && scan.col == cell_idx && !visited_reg &&
            (!finite_reg || cand < slack_reg))
        begin
            slack_next  = cand;
            finite_next = 1'b1;
            link_next   = scan.from;
        end

        unique case (cmd.cmd)
            CMD_NONE: ;
            CMD_SOLVE_INIT:
            begin
                v_next     = '0;
                u_next     = '0;
                owner_next = '0;
            end
            CMD_PHASE_INIT:
            begin
                visited_next = 1'b0;
                finite_next  = 1'b0;
                if (cell_idx == '0)
                begin
                    owner_next = cmd.owner;
                    u_next     = '0;
                end
            end
            CMD_VISIT:
            begin
                if (cmd.sel == cell_idx)
                begin
                    visited_next = 1'b1;
                end
            end
            CMD_UPDATE:
            begin
                if (visited_reg)
                begin
                    u_next = u_reg + cmd.value;
                    v_next = v_reg - cmd.value;
                end
                else if (finite_reg)
                begin
                    slack_next = slack_reg - cmd.value;
                end
            end
            CMD_MOVE:
            begin
                if (cmd.sel == cell_idx)
                begin
                    owner_next = cmd.owner;
                    u_next     = cmd.value;
                end
            end
            default: ;
        endcase

        // pass the running minimum on, taking this column if it is smaller
        token_next = token_in;
        if (!visited_reg && finite_reg && (!token_in.have || slack_reg < token_in.delta))
        begin
            token_next.have  = 1'b1;
            token_next.delta = slack_reg;
            token_next.best  = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finite_reg  <= 1'b0;
            visited_reg <= 1'b0;
            owner_reg   <= '0;
            token_reg   <= '0;
        end
        else
        begin
            finite_reg  <= finite_next;
            visited_reg <= visited_next;
            owner_reg   <= owner_next;
            token_reg   <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        u_reg     <= u_next;
        slack_reg <= slack_next;
        link_reg  <= link_next;
    end

    assign token_out  = token_reg;
    assign stat.owner = owner_reg;
    assign stat.u     = u_reg;
    assign stat.link  = link_reg;

endmodule
